### design/crlp_pkg.sv
// ----------------------------------------------------------------------------
// crlp_pkg - shared definitions for the controller reply line parser
// Types, codes and constants used by the interfaces, the step logic and the
// top level.
// ----------------------------------------------------------------------------
package crlp_pkg;

  // Largest field and parameter count that is reported.
  localparam int unsigned MAX_FIELDS = 16;
  // Field counter may run one past MAX_FIELDS.
  localparam int unsigned CNT_W      = $clog2(MAX_FIELDS + 2);
  // Fixed payload widths.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ROLE_W     = 3;
  localparam int unsigned FIELD_W    = 5;
  localparam int unsigned CODE_W     = 2;

  // Special characters.
  localparam logic [BYTE_W-1:0] CHR_STX  = 8'h02;
  localparam logic [BYTE_W-1:0] CHR_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CHR_C    = 8'h43;
  localparam logic [BYTE_W-1:0] CHR_W    = 8'h57;
  localparam logic [BYTE_W-1:0] CHR_E    = 8'h45;
  localparam logic [BYTE_W-1:0] CHR_S    = 8'h53;
  localparam logic [BYTE_W-1:0] CHR_Y    = 8'h59;
  localparam logic [BYTE_W-1:0] CHR_LA   = 8'h61;
  localparam logic [BYTE_W-1:0] CHR_LZ   = 8'h7A;
  localparam logic [BYTE_W-1:0] CHR_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_9    = 8'h39;
  localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

  // Number of command letters in field 0.
  localparam logic [1:0] CMD_LEN = 2'd3;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_TYPE   = 3'd1,
    PH_TABOPT = 3'd2,
    PH_CMD    = 3'd3,
    PH_PARAM  = 3'd4
  } phase_t;

  typedef enum logic [ROLE_W-1:0] {
    ROLE_STX     = 3'd0,
    ROLE_TYPE    = 3'd1,
    ROLE_TAB     = 3'd2,
    ROLE_CMD     = 3'd3,
    ROLE_TAIL    = 3'd4,
    ROLE_PARAM   = 3'd5,
    ROLE_IGNORED = 3'd6
  } role_t;

  typedef enum logic [CODE_W-1:0] {
    TYPE_C = 2'd0,
    TYPE_W = 2'd1,
    TYPE_E = 2'd2
  } type_code_t;

  typedef enum logic [CODE_W-1:0] {
    TAIL_NONE = 2'd0,
    TAIL_AXIS = 2'd1,
    TAIL_SYS  = 2'd2
  } tail_kind_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t           phase;
    logic [1:0]       cmd_seen;
    logic             sys_match;
    logic             tail_present;
    logic             tail_digits;
    logic [CNT_W-1:0] field_cnt;
    logic             last_tab;
    logic             line_bad;
    type_code_t       type_held;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:        PH_FIRST,
    cmd_seen:     2'd0,
    sys_match:    1'b1,
    tail_present: 1'b0,
    tail_digits:  1'b1,
    field_cnt:    '0,
    last_tab:     1'b0,
    line_bad:     1'b0,
    type_held:    TYPE_C
  };

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    role_t              role;
    logic [FIELD_W-1:0] field_number;
    logic               line_done;
    logic               line_valid;
    type_code_t         type_code;
    tail_kind_t         tail_kind;
    logic [FIELD_W-1:0] param_count;
  } result_t;

  // Expected upper-case letter of the word SYS at a given position.
  function automatic logic [BYTE_W-1:0] sys_letter(input logic [1:0] idx);
    logic [BYTE_W-1:0] chr;
    unique case (idx)
      2'd1:    chr = CHR_Y;
      default: chr = CHR_S;
    endcase
    return chr;
  endfunction

endpackage

### design/crlp_if.sv
// ----------------------------------------------------------------------------
// crlp_in_if / crlp_out_if - channels of the reply line parser
// Valid/ready channels for the input bytes and the tagged result items.
// ----------------------------------------------------------------------------
interface crlp_in_if;
  logic                          valid;
  logic                          ready;
  logic [crlp_pkg::BYTE_W-1:0]   data_byte;
  logic                          has_byte;
  logic                          is_last;

  modport source (output valid, data_byte, has_byte, is_last, input ready);
  modport sink   (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface crlp_out_if;
  logic                          valid;
  logic                          ready;
  logic [crlp_pkg::BYTE_W-1:0]   out_byte;
  logic [crlp_pkg::ROLE_W-1:0]   role;
  logic [crlp_pkg::FIELD_W-1:0]  field_number;
  logic                          line_done;
  logic                          line_valid;
  logic [crlp_pkg::CODE_W-1:0]   type_code;
  logic [crlp_pkg::CODE_W-1:0]   tail_kind;
  logic [crlp_pkg::FIELD_W-1:0]  param_count;

  modport source (output valid, out_byte, role, field_number, line_done, line_valid,
                  type_code, tail_kind, param_count, input ready);
  modport sink   (input valid, out_byte, role, field_number, line_done, line_valid,
                  type_code, tail_kind, param_count, output ready);
endinterface

### design/crlp_step.sv
// ----------------------------------------------------------------------------
// crlp_step - next-state and result logic for one reply line item
// Classifies one byte against the current parser state and, on the closing
// item, judges the whole line.
// ----------------------------------------------------------------------------
module crlp_step (
  input  crlp_pkg::state_t               st,
  input  logic [crlp_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           has_byte,
  input  logic                           is_last,
  output crlp_pkg::state_t               st_nxt,
  output crlp_pkg::result_t              res
);
  import crlp_pkg::*;

  // Byte classification and state update.
  always_comb begin
    state_t            s;
    logic [BYTE_W-1:0] ob;
    role_t             role;
    logic              ok;
    tail_kind_t        tkind;
    logic [CNT_W:0]    n;
    logic [CNT_W-1:0]  fsat;
    logic [CNT_W:0]    nsat;

    s     = st;
    ob    = '0;
    role  = ROLE_IGNORED;
    ok    = 1'b0;
    tkind = TAIL_NONE;
    n     = '0;
    nsat  = '0;

    if (has_byte) begin
      ob = data_byte;
      priority if (st.line_bad) begin
        role = ROLE_IGNORED;
      end else if (st.phase == PH_FIRST && data_byte == CHR_STX) begin
        role    = ROLE_STX;
        s.phase = PH_TYPE;
      end else if (st.phase == PH_FIRST || st.phase == PH_TYPE) begin
        if (data_byte == CHR_C || data_byte == CHR_W || data_byte == CHR_E) begin
          role        = ROLE_TYPE;
          s.type_held = (data_byte == CHR_C) ? TYPE_C :
                        (data_byte == CHR_W) ? TYPE_W : TYPE_E;
          s.phase     = PH_TABOPT;
        end else begin
          s.line_bad = 1'b1;
        end
      end else if (st.phase == PH_TABOPT && data_byte == CHR_TAB) begin
        role    = ROLE_TAB;
        s.phase = PH_CMD;
      end else if (data_byte == CHR_TAB) begin
        // A tab in the command field needs all three letters first.
        role = ROLE_TAB;
        if (st.phase != PH_PARAM && st.cmd_seen != CMD_LEN) begin
          s.line_bad = 1'b1;
          s.phase    = PH_CMD;
        end else begin
          if (st.field_cnt <= CNT_W'(MAX_FIELDS)) begin
            s.field_cnt = st.field_cnt + 1'b1;
          end
          s.last_tab = 1'b1;
          s.phase    = PH_PARAM;
        end
      end else if (st.phase == PH_PARAM) begin
        role       = ROLE_PARAM;
        s.last_tab = 1'b0;
      end else begin
        s.phase = PH_CMD;
        if (st.cmd_seen != CMD_LEN) begin
          if (data_byte >= CHR_LA && data_byte <= CHR_LZ) begin
            ob = data_byte - CASE_OFS;
          end
          role = ROLE_CMD;
          if (ob != sys_letter(st.cmd_seen)) begin
            s.sys_match = 1'b0;
          end
          s.cmd_seen = st.cmd_seen + 1'b1;
        end else begin
          role           = ROLE_TAIL;
          s.tail_present = 1'b1;
          if (data_byte < CHR_0 || data_byte > CHR_9) begin
            s.tail_digits = 1'b0;
          end
        end
      end
    end

    // Field number of this byte, saturated.
    fsat = (s.field_cnt > CNT_W'(MAX_FIELDS)) ? CNT_W'(MAX_FIELDS) : s.field_cnt;

    // Line verdict, taken on the state after this byte.
    if (is_last) begin
      ok = !s.line_bad && (s.phase == PH_CMD || s.phase == PH_PARAM) &&
           s.cmd_seen == CMD_LEN &&
           !(s.tail_present && !s.tail_digits && !s.sys_match);
      if (ok) begin
        tkind = s.tail_present ? (s.tail_digits ? TAIL_AXIS : TAIL_SYS) : TAIL_NONE;
        n = {1'b0, s.field_cnt} - {{CNT_W{1'b0}}, s.last_tab}
            + {{CNT_W{1'b0}}, (tkind == TAIL_SYS)};
        nsat = (n > (CNT_W+1)'(MAX_FIELDS)) ? (CNT_W+1)'(MAX_FIELDS) : n;
      end
    end

    res.out_byte     = ob;
    res.role         = role;
    res.field_number = FIELD_W'(fsat);
    res.line_done    = is_last;
    res.line_valid   = ok;
    res.type_code    = ok ? s.type_held : TYPE_C;
    res.tail_kind    = tkind;
    res.param_count  = FIELD_W'(nsat);

    st_nxt = is_last ? ST_RESET : s;
  end

endmodule

### design/controller_reply_line_parser.sv
// ----------------------------------------------------------------------------
// controller_reply_line_parser - tags the bytes of a motion-controller reply
// Parses a reply line one byte per transfer and reports its verdict at the
// closing item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per transfer: a byte, a flag saying whether the byte
//   belongs to the line, and a flag marking the item that closes the line.
//   out_ch returns exactly one result per input item, in order: the byte
//   (command letters upper-cased), its role and field number, and on the
//   closing item the line verdict, type, tail kind and parameter count.
//   The result of an item is on out_ch the cycle after its transfer. Throughput
//   is one item per cycle while the receiver keeps taking results, set by the
//   single result register; an item is taken whenever that register is empty
//   or being emptied in the same cycle.
//   When the receiver stalls, the pending result holds and in_ch.ready drops
//   until it is taken; no result is lost.
//   Reset (rst_n low, synchronous) empties the result register and returns
//   the parser to the start of a line. Every closing item does the same to
//   the parser state.
// ----------------------------------------------------------------------------
module controller_reply_line_parser (
  input  logic      clk,
  input  logic      rst_n,
  crlp_in_if.sink   in_ch,
  crlp_out_if.source out_ch
);
  import crlp_pkg::*;

  state_t  st_r;
  state_t  st_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    out_valid_r;
  logic    in_fire;

  // Take an item whenever the result register is free this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  crlp_step u_step (
    .st        (st_r),
    .data_byte (in_ch.data_byte),
    .has_byte  (in_ch.has_byte),
    .is_last   (in_ch.is_last),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  // Parser state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = res_r.out_byte;
  assign out_ch.role         = res_r.role;
  assign out_ch.field_number = res_r.field_number;
  assign out_ch.line_done    = res_r.line_done;
  assign out_ch.line_valid   = res_r.line_valid;
  assign out_ch.type_code    = res_r.type_code;
  assign out_ch.tail_kind    = res_r.tail_kind;
  assign out_ch.param_count  = res_r.param_count;

endmodule

### test/crlp_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crlp_tb_pkg - result tracking for the reply line parser testbench
// Holds a byte-level model of the parser. It predicts the tag and the line
// verdict for every accepted input transfer, and compares each result transfer
// with the oldest prediction.
// ----------------------------------------------------------------------------
package crlp_tb_pkg;
  import crlp_pkg::*;

  class reply_tag_checker;
    // Parser state as tracked by the prediction.
    phase_t      ph;
    int unsigned letters_seen;
    bit          sys_word_ok;
    bit          tail_seen;
    bit          tail_digits;
    int unsigned field_cnt;
    bit          ends_on_tab;
    bit          bad;
    type_code_t  type_seen;

    // Predicted results in arrival order, and run statistics.
    result_t     expected_tags[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned lines_seen;
    int unsigned lines_valid;
    int unsigned lines_saturated;

    function new();
      mismatches      = 0;
      results_checked = 0;
      lines_seen      = 0;
      lines_valid     = 0;
      lines_saturated = 0;
      restart_line();
    endfunction

    // Every closing item returns the parser to the start of a line.
    function void restart_line();
      ph           = PH_FIRST;
      letters_seen = 0;
      sys_word_ok  = 1'b1;
      tail_seen    = 1'b0;
      tail_digits  = 1'b1;
      field_cnt    = 0;
      ends_on_tab  = 1'b0;
      bad          = 1'b0;
      type_seen    = TYPE_C;
    endfunction

    function int unsigned capped(int unsigned v);
      return (v > MAX_FIELDS) ? MAX_FIELDS : v;
    endfunction

    // A separator tab opens the next field; the counter stops one past the cap.
    function void open_field();
      if (field_cnt <= MAX_FIELDS) field_cnt++;
      ends_on_tab = 1'b1;
    endfunction

    // Works out the tag of one accepted item, and the verdict if it closes the line.
    function void predict_tag(logic [BYTE_W-1:0] b, logic has, logic last);
      result_t           r;
      logic [BYTE_W-1:0] ob;
      role_t             role;
      int unsigned       n;
      ob   = '0;
      role = ROLE_IGNORED;
      if (has) begin
        ob = b;
        if (bad) begin
          role = ROLE_IGNORED;
        end else if (ph == PH_FIRST && b == CHR_STX) begin
          role = ROLE_STX;
          ph   = PH_TYPE;
        end else if (ph == PH_FIRST || ph == PH_TYPE) begin
          // Type letter; anything else spoils the rest of the line.
          if (b == CHR_C || b == CHR_W || b == CHR_E) begin
            role = ROLE_TYPE;
            if (b == CHR_C) type_seen = TYPE_C;
            else if (b == CHR_W) type_seen = TYPE_W;
            else type_seen = TYPE_E;
            ph = PH_TABOPT;
          end else begin
            bad = 1'b1;
          end
        end else if (ph == PH_TABOPT && b == CHR_TAB) begin
          role = ROLE_TAB;
          ph   = PH_CMD;
        end else if (ph != PH_PARAM) begin
          // Command field: three letters, then an optional tail.
          ph = PH_CMD;
          if (b == CHR_TAB) begin
            role = ROLE_TAB;
            if (letters_seen < CMD_LEN) begin
              bad = 1'b1;
            end else begin
              open_field();
              ph = PH_PARAM;
            end
          end else if (letters_seen < CMD_LEN) begin
            if (b >= CHR_LA && b <= CHR_LZ) ob = b - CASE_OFS;
            role = ROLE_CMD;
            if (ob != ((letters_seen == 1) ? CHR_Y : CHR_S)) sys_word_ok = 1'b0;
            letters_seen++;
          end else begin
            role      = ROLE_TAIL;
            tail_seen = 1'b1;
            if (b < CHR_0 || b > CHR_9) tail_digits = 1'b0;
          end
        end else if (b == CHR_TAB) begin
          role = ROLE_TAB;
          open_field();
        end else begin
          role        = ROLE_PARAM;
          ends_on_tab = 1'b0;
        end
      end

      r              = '0;
      r.out_byte     = ob;
      r.role         = role;
      r.field_number = FIELD_W'(capped(field_cnt));
      r.line_done    = last;

      // Line verdict on the closing item.
      if (last) begin
        lines_seen++;
        if (!bad && (ph == PH_CMD || ph == PH_PARAM) && letters_seen == CMD_LEN &&
            !(tail_seen && !tail_digits && !sys_word_ok)) begin
          n            = field_cnt - (ends_on_tab ? 1 : 0);
          r.line_valid = 1'b1;
          r.type_code  = type_seen;
          if (!tail_seen) begin
            r.tail_kind = TAIL_NONE;
          end else if (tail_digits) begin
            r.tail_kind = TAIL_AXIS;
          end else begin
            r.tail_kind = TAIL_SYS;
            n++;
          end
          if (n > MAX_FIELDS) lines_saturated++;
          r.param_count = FIELD_W'(capped(n));
          lines_valid++;
        end
        restart_line();
      end
      expected_tags.insert(expected_tags.size(), r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        mismatches++;
        $display("%0t: %s mismatch on result %0d: expected %0d, actual %0d",
                 $time, name, results_checked, want, seen);
      end
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_tag(result_t got);
      result_t want;
      if (expected_tags.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing predicted: expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_tags.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("role", want.role, got.role);
      compare_field("field_number", want.field_number, got.field_number);
      compare_field("line_done", want.line_done, got.line_done);
      compare_field("line_valid", want.line_valid, got.line_valid);
      compare_field("type_code", want.type_code, got.type_code);
      compare_field("tail_kind", want.tail_kind, got.tail_kind);
      compare_field("param_count", want.param_count, got.param_count);
      results_checked++;
    endfunction
  endclass

endpackage

### test/tb_controller_reply_line_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_controller_reply_line_parser - testbench for the reply line parser
// Feeds directed reply lines and then random well-formed, broken and noise
// lines, with random sender gaps and receiver stalls, including long receiver
// hold-offs. Every result is checked field by field against a prediction.
// ----------------------------------------------------------------------------
module tb_controller_reply_line_parser;
  import crlp_pkg::*;
  import crlp_tb_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1450;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has;
    logic              last;
  } line_item_t;

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_SPARSE
  } rx_mode_t;

  logic clk;
  logic rst_n;

  crlp_in_if  in_ch ();
  crlp_out_if out_ch ();

  controller_reply_line_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  reply_tag_checker tags;
  line_item_t       line_items[$];
  int unsigned      busy_items     = 0;
  int unsigned      accepted_items = 0;
  int unsigned      burst_left     = 0;
  int unsigned      holdoffs       = 0;
  int unsigned      cycle_count    = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, tags.expected_tags.size());
      $display("FAIL controller_reply_line_parser");
      $finish;
    end
  end

  // Result transfers are checked as they happen.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tags.check_tag({out_ch.out_byte, out_ch.role, out_ch.field_number, out_ch.line_done,
                      out_ch.line_valid, out_ch.type_code, out_ch.tail_kind,
                      out_ch.param_count});
  end

  // Items that carry a byte or close a line count towards the target.
  function automatic void push_item(logic [BYTE_W-1:0] data, logic has, logic last);
    line_item_t it;
    it = '{data, has, last};
    line_items.insert(line_items.size(), it);
    if (has || last) busy_items++;
  endfunction

  function automatic void add_text(string s, bit closes);
    for (int i = 0; i < s.len(); i++)
      push_item(s[i], 1'b1, closes && (i == s.len() - 1));
  endfunction

  // Queues a line, with the odd empty item slipped in; a bare item may close it.
  function automatic void add_line(input logic [BYTE_W-1:0] txt[$], input bit bare);
    foreach (txt[i]) begin
      if ($urandom_range(0, 24) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(txt[i], 1'b1, !bare && (i == txt.size() - 1));
    end
    if (bare) push_item(8'($urandom), 1'b0, 1'b1);
  endfunction

  function automatic logic [BYTE_W-1:0] not_tab();
    logic [BYTE_W-1:0] b;
    b = 8'($urandom);
    while (b == CHR_TAB) b = 8'($urandom);
    return b;
  endfunction

  // Takes an upper-case letter and returns it in either case.
  function automatic logic [BYTE_W-1:0] flip_case(logic [BYTE_W-1:0] up);
    return ($urandom_range(0, 1) == 1) ? up : up + CASE_OFS;
  endfunction

  // Mostly well-formed replies with random content; the rest broken or noise.
  function automatic void add_random_line();
    logic [BYTE_W-1:0] txt[$];
    int unsigned       pick;
    int unsigned       n_params;
    int unsigned       cut;
    bit                bare;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(0, 10)) txt.insert(txt.size(), 8'($urandom));
    end else begin
      if ($urandom_range(0, 1) == 1) txt.insert(txt.size(), CHR_STX);
      case ($urandom_range(0, 2))
        0:       txt.insert(txt.size(), CHR_C);
        1:       txt.insert(txt.size(), CHR_W);
        default: txt.insert(txt.size(), CHR_E);
      endcase
      if ($urandom_range(0, 1) == 1) txt.insert(txt.size(), CHR_TAB);
      // Command letters, often the word SYS in mixed case.
      if ($urandom_range(0, 3) == 0) begin
        txt.insert(txt.size(), flip_case(CHR_S));
        txt.insert(txt.size(), flip_case(CHR_Y));
        txt.insert(txt.size(), flip_case(CHR_S));
      end else begin
        repeat (3)
          txt.insert(txt.size(), ($urandom_range(0, 9) == 0) ? not_tab() :
                     flip_case(CHR_LA - CASE_OFS + 8'($urandom_range(0, 25))));
      end
      // Tail: none, an axis number or arbitrary text.
      case ($urandom_range(0, 3))
        1:       repeat ($urandom_range(1, 3))
                   txt.insert(txt.size(), CHR_0 + 8'($urandom_range(0, 9)));
        2:       repeat ($urandom_range(1, 3)) txt.insert(txt.size(), not_tab());
        default: ;
      endcase
      // Parameters; now and then enough to saturate the count.
      n_params = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
      repeat (n_params) begin
        txt.insert(txt.size(), CHR_TAB);
        repeat ($urandom_range(0, 3)) txt.insert(txt.size(), not_tab());
      end
      if ($urandom_range(0, 3) == 0) txt.insert(txt.size(), CHR_TAB);
      // Broken replies: cut short, or one byte replaced.
      if (pick < 24) begin
        if ($urandom_range(0, 1) == 1) begin
          cut = $urandom_range(0, txt.size() - 1);
          while (txt.size() > cut) void'(txt.pop_back());
        end else begin
          txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
        end
      end
    end
    bare = (txt.size() == 0) || ($urandom_range(0, 3) == 0);
    add_line(txt, bare);
  endfunction

  // Offers one item in bursts with random gaps; returns at a falling edge.
  task automatic send_item(input line_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'($urandom);
        in_ch.has_byte  <= 1'($urandom);
        in_ch.is_last   <= 1'($urandom);
        @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= it.data;
    in_ch.has_byte  <= it.has;
    in_ch.is_last   <= it.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tags.predict_tag(it.data, it.has, it.last);
    accepted_items++;
    @(negedge clk);
  endtask

  // Receiver: changing stall patterns, and a long hold-off now and then.
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned tick;
    int unsigned next_hold;
    int unsigned hold_left;
    mode         = RX_OPEN;
    mode_left    = 0;
    tick         = 0;
    next_hold    = 300;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left == 0 && next_hold <= 1300 && accepted_items >= next_hold) begin
        hold_left = $urandom_range(60, 100);
        next_hold += 500;
        holdoffs++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom);
          RX_EVERY4: out_ch.ready <= (tick % 4) != 0;
          default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    tags            = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte  = 1'b0;
    in_ch.is_last   = 1'b0;

    // Empty line, after an item that carries nothing and does not close.
    push_item(8'hA5, 1'b0, 1'b0);
    push_item(8'h5A, 1'b0, 1'b1);
    // STX alone, then a type letter alone.
    push_item(CHR_STX, 1'b1, 1'b1);
    add_text("C", 1'b1);
    // Bad type letter; what follows is ignored.
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(CHR_W, 1'b1, 1'b1);
    // Tab before the second command letter.
    add_text("E\ta\tx", 1'b1);
    // SYS with a text tail, an empty parameter and a trailing tab, closed bare.
    push_item(CHR_STX, 1'b1, 1'b0);
    add_text("Csysz\t\t", 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    // Axis tail and a parameter holding a zero byte.
    add_text("Wmov7\t", 1'b0);
    push_item(8'h00, 1'b1, 1'b1);
    // Too few command letters.
    add_text("Ca", 1'b1);

    begin
      int unsigned goal;
      goal = busy_items + ITEM_TARGET;
      while (busy_items < goal) add_random_line();
    end

    // Synchronous reset, held from the start and released at a falling edge.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (line_items[i]) send_item(line_items[i]);
    in_ch.valid <= 1'b0;

    while (tags.expected_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d reply lines (%0d well formed, %0d with a saturated count) through",
             tags.lines_seen, tags.lines_valid, tags.lines_saturated);
    $display("%0d checked results, with %0d long receiver hold-offs; %0d mismatches.",
             tags.results_checked, holdoffs, tags.mismatches);
    if (tags.mismatches == 0) begin
      $display("PASS controller_reply_line_parser");
    end else begin
      $display("FAIL controller_reply_line_parser");
    end
    $finish;
  end

endmodule

### sim.f
design/crlp_pkg.sv
design/crlp_if.sv
design/crlp_step.sv
design/controller_reply_line_parser.sv
test/crlp_tb_pkg.sv
test/tb_controller_reply_line_parser.sv
